FILE: sv/rpc_pkg.sv
// Shared types, constants and helpers of the row permutation cipher.
package rpc_pkg;

  localparam int unsigned MAX_KEY_DEF = 8;
  localparam logic [7:0]  PAD_CHAR    = 8'h30;
  localparam logic [3:0]  KEY_LEN_RST = 4'd8;

  // Register select, taken from paddr[3].
  localparam logic REG_KEY_LENGTH = 1'b0;
  localparam logic REG_KEY_BYTES  = 1'b1;

  typedef struct packed {
    logic [3:0] count;
    logic       last;
  } row_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } row_release_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       row_last;
    logic       message_done;
  } out_ent_t;

  function automatic logic [3:0] row_width(logic [3:0] kl, logic [3:0] max_key);
    logic [3:0] n;
    n = kl;
    if (kl == 4'd0) begin
      n = 4'd1;
    end else if (kl > max_key) begin
      n = max_key;
    end
    return n;
  endfunction

endpackage

FILE: sv/rpc_if.sv
// Valid/ready stream interfaces for message bytes and cipher bytes.
interface rpc_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface rpc_cipher_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       row_last;
  logic       message_done;

  modport source (output valid, output cipher_byte, output row_last,
                  output message_done, input ready);
  modport sink (input valid, input cipher_byte, input row_last,
                input message_done, output ready);
endinterface

FILE: sv/row_permutation_cipher.sv
// Top level of the keyed row permutation cipher.
//
//   port       dir  kind        carries
//   msg_i      in   valid/ready msg_byte, msg_last
//   cipher_o   out  valid/ready cipher_byte, row_last, message_done
//   APB        in   write/read  key_length (0x0), key_bytes (0x8)
//
// One byte in and one byte out per cycle sustained while cipher_o is not stalled;
// rows alternate between two memory banks, so filling one row overlaps emitting the
// previous one. The first byte of a full row is offered once its completing byte is
// taken and has passed the memory read and the queue write; the read port sets the rate.
// Reset clears fill count, bank flags and output queue; the memory is not cleared.
// A stalled output holds two queued bytes, then reading and, once both banks
// are full, input acceptance stop.
module row_permutation_cipher
  import rpc_pkg::*;
#(
  parameter int unsigned MaxKey = MAX_KEY_DEF,
  localparam int unsigned ColW = $clog2(MaxKey)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpc_msg_if.sink       msg_i,
  rpc_cipher_if.source  cipher_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [3:0]      key_length;
  logic [63:0]     key_bytes;
  logic [3:0]      row_w;
  logic            mem_we, mem_re;
  logic [ColW:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic [1:0]      bank_full;
  row_desc_t [1:0] desc;
  row_release_t    rel;

  assign row_w = row_width(key_length, 4'(MaxKey));

  rpc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .key_length_o (key_length),
    .key_bytes_o  (key_bytes)
  );

  rpc_row_mem #(.Depth(2 ** (ColW + 1))) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rpc_fill #(.MaxKey(MaxKey)) u_fill (
    .clk_i,
    .rst_ni,
    .msg_i       (msg_i),
    .row_width_i (row_w),
    .release_i   (rel),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .bank_full_o (bank_full),
    .desc_o      (desc)
  );

  rpc_emit #(.MaxKey(MaxKey)) u_emit (
    .clk_i,
    .rst_ni,
    .row_width_i (row_w),
    .key_bytes_i (key_bytes),
    .bank_full_i (bank_full),
    .desc_i      (desc),
    .release_o   (rel),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .cipher_o    (cipher_o)
  );

endmodule

FILE: sv/rpc_cfg.sv
// APB register file holding key length and key bytes.
module rpc_cfg
  import rpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [3:0]  key_length_o,
  output logic [63:0] key_bytes_o
);

  logic [3:0]  key_length_q, key_length_d;
  logic [63:0] key_bytes_q, key_bytes_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    key_length_d = key_length_q;
    key_bytes_d  = key_bytes_q;
    if (wr_en) begin
      case (paddr[3])
        REG_KEY_LENGTH: key_length_d = pwdata[3:0];
        REG_KEY_BYTES:  key_bytes_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_KEY_LENGTH: prdata = {60'd0, key_length_q};
      REG_KEY_BYTES:  prdata = key_bytes_q;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RST;
      key_bytes_q  <= '0;
    end else begin
      key_length_q <= key_length_d;
      key_bytes_q  <= key_bytes_d;
    end
  end

  assign key_length_o = key_length_q;
  assign key_bytes_o  = key_bytes_q;

endmodule

FILE: sv/rpc_row_mem.sv
// Two-bank row memory, one write port and one registered read port.
module rpc_row_mem #(
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rpc_fill.sv
// Row fill side: writes message bytes into the free bank and hands full rows over.
module rpc_fill
  import rpc_pkg::*;
#(
  parameter int unsigned MaxKey = MAX_KEY_DEF,
  localparam int unsigned ColW = $clog2(MaxKey)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpc_msg_if.sink             msg_i,
  input  logic [3:0]          row_width_i,
  input  row_release_t        release_i,
  output logic                mem_we_o,
  output logic [ColW:0]       mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic [1:0]          bank_full_o,
  output row_desc_t [1:0]     desc_o
);

  logic            wb_q, wb_d;
  logic [3:0]      fill_cnt_q, fill_cnt_d;
  logic [1:0]      bank_full_q, bank_full_d;
  row_desc_t [1:0] desc_q, desc_d;
  logic            accept;
  logic [3:0]      count;

  assign msg_i.ready = ~bank_full_q[wb_q];
  assign accept      = msg_i.valid & msg_i.ready;
  assign count       = fill_cnt_q + 4'd1;

  assign mem_we_o    = accept;
  assign mem_waddr_o = {wb_q, fill_cnt_q[ColW-1:0]};
  assign mem_wdata_o = msg_i.msg_byte;

  always_comb begin
    wb_d        = wb_q;
    fill_cnt_d  = fill_cnt_q;
    bank_full_d = bank_full_q;
    desc_d      = desc_q;
    if (release_i.valid) begin
      bank_full_d[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if (count >= row_width_i || msg_i.msg_last) begin
        bank_full_d[wb_q] = 1'b1;
        desc_d[wb_q]      = '{count: count, last: msg_i.msg_last};
        wb_d              = ~wb_q;
        fill_cnt_d        = 4'd0;
      end else begin
        fill_cnt_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q        <= 1'b0;
      fill_cnt_q  <= 4'd0;
      bank_full_q <= 2'b00;
    end else begin
      wb_q        <= wb_d;
      fill_cnt_q  <= fill_cnt_d;
      bank_full_q <= bank_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign bank_full_o = bank_full_q;
  assign desc_o      = desc_q;

  a_full_bank_no_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_full_q[wb_q] |-> fill_cnt_q == 4'd0)
    else $error("partial row held in a full bank");

  a_release_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_i.valid |-> bank_full_q[release_i.bank])
    else $error("release of a bank that holds no row");

  a_fill_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q < 4'(MaxKey))
    else $error("fill count out of range");

endmodule

FILE: sv/rpc_emit.sv
// Row emit side: ranks columns, reads the full bank and queues cipher bytes.
module rpc_emit
  import rpc_pkg::*;
#(
  parameter int unsigned MaxKey = MAX_KEY_DEF,
  localparam int unsigned ColW = $clog2(MaxKey)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          row_width_i,
  input  logic [63:0]         key_bytes_i,
  input  logic [1:0]          bank_full_i,
  input  row_desc_t [1:0]     desc_i,
  output row_release_t        release_o,
  output logic                mem_re_o,
  output logic [ColW:0]       mem_raddr_o,
  input  logic [7:0]          mem_rdata_i,
  rpc_cipher_if.source        cipher_o
);

  logic            rb_q, rb_d;
  logic [ColW-1:0] col_q, col_d;
  logic            rd_v_q, rd_pad_q, rd_last_q, rd_done_q;
  logic            rd_pad_d, rd_last_d, rd_done_d;
  out_ent_t        ent_q [2];
  logic            head_q, head_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0]      rank_acc;
  logic [ColW-1:0] rank;
  logic [7:0]      cj, ck;
  logic [1:0]      occ;
  logic            pop, push, can_issue, issue, col_end, tail;
  row_desc_t       cur_desc;

  always_comb begin
    rank_acc = 4'd0;
    ck       = 8'd0;
    cj       = key_bytes_i[{col_q, 3'b000} +: 8];
    for (int k = 0; k < MaxKey; k++) begin
      ck = key_bytes_i[8*k +: 8];
      if (4'(k) < row_width_i && (ck < cj || (ck == cj && ColW'(k) < col_q))) begin
        rank_acc = rank_acc + 4'd1;
      end
    end
  end
  assign rank = rank_acc[ColW-1:0];

  assign cur_desc  = desc_i[rb_q];
  assign pop       = cipher_o.valid & cipher_o.ready;
  assign push      = rd_v_q;
  assign occ       = cnt_q + {1'b0, rd_v_q};
  assign can_issue = (occ < 2'd2) | pop;
  assign issue     = bank_full_i[rb_q] & can_issue;
  assign col_end   = ({{(4-ColW){1'b0}}, col_q} + 4'd1) == row_width_i;

  assign mem_re_o    = issue;
  assign mem_raddr_o = {rb_q, rank};
  assign release_o   = '{valid: issue & col_end, bank: rb_q};

  always_comb begin
    rb_d      = rb_q;
    col_d     = col_q;
    rd_pad_d  = rd_pad_q;
    rd_last_d = rd_last_q;
    rd_done_d = rd_done_q;
    if (issue) begin
      rd_pad_d  = ({{(4-ColW){1'b0}}, rank} >= cur_desc.count);
      rd_last_d = col_end;
      rd_done_d = col_end & cur_desc.last;
      if (col_end) begin
        col_d = '0;
        rb_d  = ~rb_q;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  assign tail   = head_q ^ cnt_q[0];
  assign head_d = head_q ^ pop;
  assign cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q   <= 1'b0;
      col_q  <= '0;
      rd_v_q <= 1'b0;
      head_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      rb_q   <= rb_d;
      col_q  <= col_d;
      rd_v_q <= issue;
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pad_q  <= rd_pad_d;
    rd_last_q <= rd_last_d;
    rd_done_q <= rd_done_d;
    if (push) begin
      ent_q[tail] <= '{cipher_byte:  rd_pad_q ? PAD_CHAR : mem_rdata_i,
                       row_last:     rd_last_q,
                       message_done: rd_done_q};
    end
  end

  assign cipher_o.valid        = cnt_q != 2'd0;
  assign cipher_o.cipher_byte  = ent_q[head_q].cipher_byte;
  assign cipher_o.row_last     = ent_q[head_q].row_last;
  assign cipher_o.message_done = ent_q[head_q].message_done;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + {1'b0, rd_v_q}) <= 2'd2)
    else $error("output queue overrun");

  a_done_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cipher_o.valid && cipher_o.message_done) |-> cipher_o.row_last)
    else $error("message end away from row end");

  a_issue_from_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != '0) |-> bank_full_i[rb_q])
    else $error("row emission interrupted");

endmodule

FILE: bench/row_permutation_cipher_test.sv
// Self-checking bench for the row permutation cipher: streams, key registers and row predictor.
module row_permutation_cipher_test
  import rpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KEY      = MAX_KEY_DEF;
  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 140;

  localparam logic [3:0] ADDR_KEY_LENGTH = 4'h0;
  localparam logic [3:0] ADDR_KEY_BYTES  = 4'h8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  rpc_msg_if    msg_ch ();
  rpc_cipher_if cipher_ch ();

  row_permutation_cipher u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .msg_i    (msg_ch),
    .cipher_o (cipher_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  logic [3:0]  key_len_q = KEY_LEN_RST;
  logic [63:0] key_q     = '0;
  logic [7:0]  row_buf [MAX_KEY];
  int unsigned fill_q    = 0;

  out_ent_t    cipher_expected [$];
  bit          quiet;
  int unsigned errors      = 0;
  int unsigned bytes_in    = 0;
  int unsigned bytes_out   = 0;
  int unsigned rows_out    = 0;
  int unsigned done_rows   = 0;
  int unsigned reg_writes  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_run    = 0;

  function automatic int unsigned span_of(logic [3:0] kl);
    if (kl == 4'd0) return 1;
    if (kl > MAX_KEY) return MAX_KEY;
    return kl;
  endfunction

  function automatic int unsigned rank_of(int unsigned j, int unsigned n);
    int unsigned r;
    logic [7:0]  cj;
    logic [7:0]  ck;
    r  = 0;
    cj = key_q[8*j +: 8];
    for (int unsigned k = 0; k < n; k++) begin
      ck = key_q[8*k +: 8];
      if (ck < cj || (ck == cj && k < j)) r++;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int unsigned style;
    style = $urandom_range(0, 2);
    for (int unsigned i = 0; i < 8; i++) begin
      case (style)
        0: k[8*i +: 8] = 8'($urandom_range(8'h41, 8'h44));
        1: k[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: k[8*i +: 8] = 8'($urandom);
      endcase
    end
    return k;
  endfunction

  function automatic int unsigned field_bad(string name, logic [7:0] want, logic [7:0] got);
    if (got === want) return 0;
    $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    return 1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    int unsigned cnt;
    int unsigned r;
    out_ent_t    e;
    n = span_of(key_len_q);
    if (fill_q < MAX_KEY) row_buf[fill_q] = b;
    cnt = fill_q + 1;
    if (cnt < n && !last) begin
      fill_q = cnt;
      return;
    end
    for (int unsigned j = 0; j < n; j++) begin
      r = rank_of(j, n);
      e.cipher_byte  = (r < cnt && r < MAX_KEY) ? row_buf[r] : PAD_CHAR;
      e.row_last     = (j + 1 == n);
      e.message_done = e.row_last && last;
      cipher_expected.push_back(e);
    end
    fill_q = 0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    msg_ch.valid    <= 1'b1;
    msg_ch.msg_byte <= b;
    msg_ch.msg_last <= last;
    @(posedge clk_i);
    while (!msg_ch.ready) @(posedge clk_i);
    absorb_byte(b, last);
    bytes_in++;
  endtask

  // hold the sender until every expected byte is out, then let the block settle
  task automatic flush_rows();
    msg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (cipher_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr == ADDR_KEY_LENGTH) key_len_q = data[3:0];
    else key_q = data;
    reg_writes++;
  endtask

  task automatic rekey_random();
    logic [63:0] v;
    int unsigned which;
    which = $urandom_range(0, 2);
    if (which != 1) begin
      v      = {$urandom, $urandom};
      v[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
      reg_write(ADDR_KEY_LENGTH, v);
    end
    if (which != 0) reg_write(ADDR_KEY_BYTES, pick_key());
  endtask

  // reset key: all ties, so rows pass in order; full row closed by last, then a padded row
  task automatic test_reset_key();
    logic [7:0] pattern [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    for (int unsigned i = 0; i < 8; i++) send_byte(pattern[i], i == 7);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // saturated width with a reversing key, zero width, ignored high key bytes
  task automatic test_key_limits();
    flush_rows();
    reg_write(ADDR_KEY_BYTES, 64'h0102_0304_0506_0708);
    reg_write(ADDR_KEY_LENGTH, 64'hF);
    for (int unsigned i = 0; i < 5; i++) send_byte(8'($urandom), i == 4);
    flush_rows();
    reg_write(ADDR_KEY_LENGTH, 64'h0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    flush_rows();
    reg_write(ADDR_KEY_BYTES, 64'hFFFF_FFFF_FF00_0001);
    reg_write(ADDR_KEY_LENGTH, 64'h3);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // width lowered and key replaced while a row is part filled
  task automatic test_mid_row_rekey();
    flush_rows();
    reg_write(ADDR_KEY_BYTES, {$urandom, $urandom});
    reg_write(ADDR_KEY_LENGTH, 64'h6);
    for (int unsigned i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    flush_rows();
    reg_write(ADDR_KEY_LENGTH, 64'h2);
    send_byte(8'($urandom), 1'b0);
    flush_rows();
    reg_write(ADDR_KEY_LENGTH, 64'h5);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    flush_rows();
    reg_write(ADDR_KEY_BYTES, pick_key());
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    bit          ends;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        flush_rows();
        rekey_random();
      end
      quiet = ($urandom_range(0, 4) == 0);
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
      ends  = ($urandom_range(0, 9) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        if (i != 0 && $urandom_range(0, 29) == 0) begin
          flush_rows();
          if ($urandom_range(0, 1) != 0) rekey_random();
        end
        send_byte(8'($urandom), ends && (i + 1 == len));
      end
      sent += len;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cipher_ch.valid && cipher_ch.ready) begin
      if (cipher_expected.size() == 0) begin
        $display("%0t ns: cipher byte %h with nothing expected", $time, cipher_ch.cipher_byte);
        errors++;
      end else begin
        out_ent_t e;
        e = cipher_expected.pop_front();
        errors += field_bad("cipher_byte", e.cipher_byte, cipher_ch.cipher_byte);
        errors += field_bad("row_last", {7'b0, e.row_last}, {7'b0, cipher_ch.row_last});
        errors += field_bad("message_done", {7'b0, e.message_done},
                            {7'b0, cipher_ch.message_done});
        if (e.row_last) rows_out++;
        if (e.message_done) done_rows++;
      end
      bytes_out++;
    end
    if (!rst_ni) begin
      cipher_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      cipher_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      cipher_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((msg_ch.valid && msg_ch.ready) || (cipher_ch.valid && cipher_ch.ready)
        || (psel && penable)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, idle_run);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    msg_ch.valid    <= 1'b0;
    msg_ch.msg_byte <= '0;
    msg_ch.msg_last <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    quiet           = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_limits();
    test_mid_row_rekey();
    test_random_traffic();

    flush_rows();
    repeat (4 * SETTLE) @(posedge clk_i);
    $display("Sent %0d message bytes, checked %0d cipher bytes in %0d rows (%0d messages).",
             bytes_in, bytes_out, rows_out, done_rows);
    $display("Key registers written %0d times, widths zero to fifteen, %0d mismatches.",
             reg_writes, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
